// ===== hdl/char_lcd_nibble_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// char lcd nibble sequencer assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define CLNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/clns_pkg.sv =====
// ----------------------------------------------------------------------------
// clns_pkg
// types, codes and the power-up script of the character lcd nibble sequencer
// ----------------------------------------------------------------------------
package clns_pkg;

  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int WAIT_W     = 16;
  localparam int STEP_W     = 5;
  localparam int INIT_STEPS = 17;

  localparam logic [WAIT_W-1:0] SETTLE_RESET = 16'd50;
  localparam logic [WAIT_W-1:0] CLEAR_RESET  = 16'd2000;
  localparam logic [WAIT_W-1:0] WAIT_15MS    = 16'd15000;
  localparam logic [WAIT_W-1:0] WAIT_5MS     = 16'd5000;
  localparam logic [WAIT_W-1:0] WAIT_1MS     = 16'd1000;
  localparam logic [WAIT_W-1:0] WAIT_NONE    = 16'd0;

  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_DATA   = 3'd1,
    OP_CMD    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_GOTO   = 3'd4,
    OP_CURSOR = 3'd5
  } opcode_t;

  typedef enum logic {
    REG_SETTLE = 1'b0,
    REG_CLEAR  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } run_state_t;

  typedef enum logic [1:0] {
    WAIT_CONST,
    WAIT_SETTLE,
    WAIT_CLEAR
  } wait_sel_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;
    logic       cursor_on;
    logic       cursor_blink;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic [3:0]        nibble;
    logic              strobe_res;
    logic [WAIT_W-1:0] wait_us;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [WAIT_W-1:0] write_settle_us;
    logic [WAIT_W-1:0] clear_wait_us;
  } cfg_t;

  typedef struct packed {
    wait_sel_t         wsel;
    logic [3:0]        nibble;
    logic              strobe;
    logic [WAIT_W-1:0] wconst;
  } script_ent_t;

  // power-up script, one entry per step
  function automatic script_ent_t init_step(input logic [STEP_W-1:0] idx);
    script_ent_t e;
    e = '{wsel: WAIT_CONST, nibble: 4'h0, strobe: 1'b0, wconst: WAIT_NONE};
    case (idx)
      5'd0:  e.wconst = WAIT_15MS;
      5'd1, 5'd2, 5'd3: begin
        e.nibble = NIB_WAKE;
        e.strobe = 1'b1;
        e.wconst = WAIT_5MS;
      end
      5'd4: begin
        e.nibble = NIB_4BIT;
        e.strobe = 1'b1;
      end
      5'd5:  e.wconst = WAIT_1MS;
      5'd6:  begin e.nibble = CMD_FUNC_SET[7:4]; e.strobe = 1'b1; end
      5'd7:  begin e.nibble = CMD_FUNC_SET[3:0]; e.strobe = 1'b1; e.wsel = WAIT_SETTLE; end
      5'd8:  begin e.nibble = CMD_DISP_OFF[7:4]; e.strobe = 1'b1; end
      5'd9:  begin e.nibble = CMD_DISP_OFF[3:0]; e.strobe = 1'b1; e.wsel = WAIT_SETTLE; end
      5'd10: begin e.nibble = CMD_CLEAR[7:4];    e.strobe = 1'b1; end
      5'd11: begin e.nibble = CMD_CLEAR[3:0];    e.strobe = 1'b1; e.wsel = WAIT_SETTLE; end
      5'd12: e.wsel = WAIT_CLEAR;
      5'd13: begin e.nibble = CMD_ENTRY[7:4];    e.strobe = 1'b1; end
      5'd14: begin e.nibble = CMD_ENTRY[3:0];    e.strobe = 1'b1; e.wsel = WAIT_SETTLE; end
      5'd15: begin e.nibble = CMD_DISP_ON[7:4];  e.strobe = 1'b1; end
      5'd16: begin e.nibble = CMD_DISP_ON[3:0];  e.strobe = 1'b1; e.wsel = WAIT_SETTLE; end
      default: e.wconst = WAIT_NONE;
    endcase
    return e;
  endfunction

endpackage

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// a taken item is registered first, then its first step enters the output register
// throughput: one step per cycle while the output is not stalled, from a step counter
//   driving the shared step unit; unused opcodes are taken and dropped with no step
// the next item is taken once the last step is in the output register
// reset (rst_n, synchronous, active low) empties the output register, idles
//   the sequencer and loads settle 50 us and clear 2000 us
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// turns lcd requests into timed 4-bit nibble steps with a config port
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_assert.svh"

module char_lcd_nibble_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  clns_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output clns_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clns_pkg::PADDR_W-1:0]  paddr,
  input  logic [clns_pkg::PDATA_W-1:0]  pwdata,
  output logic [clns_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  clns_pkg::cfg_t               cfg;
  clns_pkg::run_state_t         state_r, state_nxt;
  clns_pkg::opcode_t            op_r, op_nxt;
  logic [7:0]                   byte_r, byte_nxt;
  logic [clns_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  clns_pkg::out_item_t          out_data_r, out_data_nxt;
  clns_pkg::out_item_t          step;
  logic                         in_take;
  logic                         slot_free;
  logic                         op_known;
  logic [7:0]                   req_byte;

  clns_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clns_step_unit u_step (
    .opcode   (op_r),
    .byte_val (byte_r),
    .step_idx (step_r),
    .cfg      (cfg),
    .step     (step)
  );

  assign in_ready  = (state_r == clns_pkg::ST_IDLE);
  assign in_take   = in_valid & in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign op_known  = (in_data.opcode <= 3'(clns_pkg::OP_CURSOR));

  // byte that the request sends
  always_comb begin
    case (clns_pkg::opcode_t'(in_data.opcode))
      clns_pkg::OP_CLEAR:  req_byte = clns_pkg::CMD_CLEAR;
      clns_pkg::OP_GOTO:   req_byte = {1'b1, in_data.row, in_data.column};
      clns_pkg::OP_CURSOR: req_byte = {6'b000011, in_data.cursor_on, in_data.cursor_blink};
      default:             req_byte = in_data.byte_value;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      clns_pkg::ST_IDLE: begin
        if (in_take && op_known) begin
          state_nxt = clns_pkg::ST_RUN;
          op_nxt    = clns_pkg::opcode_t'(in_data.opcode);
          byte_nxt  = req_byte;
          step_nxt  = '0;
        end
      end
      clns_pkg::ST_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = step;
          step_nxt      = step_r + 1'b1;
          if (step.last) begin
            state_nxt = clns_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = clns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clns_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CLNS_ASSERT_NEXT(a_no_step_when_idle,
    state_r == clns_pkg::ST_IDLE && out_valid_r && out_ready, !out_valid_r,
    "step produced while sequencer idle")
  `CLNS_ASSERT_NOW(a_step_in_range, state_r == clns_pkg::ST_RUN,
    step_r < clns_pkg::STEP_W'(clns_pkg::INIT_STEPS), "step index past script end")
  `CLNS_ASSERT_NEXT(a_known_op_runs, in_valid && in_ready && op_known,
    state_r == clns_pkg::ST_RUN, "accepted request did not start")
  `CLNS_ASSERT_NOW(a_pure_wait_quiet, out_valid_r && !out_data_r.strobe_res,
    out_data_r.nibble == 4'h0 && !out_data_r.reg_select,
    "pure wait step drives data or register select")

endmodule

// ===== hdl/clns_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// clns_cfg_regs
// apb register file holding the settle and clear waits
// ----------------------------------------------------------------------------
module clns_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clns_pkg::PADDR_W-1:0]  paddr,
  input  logic [clns_pkg::PDATA_W-1:0]  pwdata,
  output logic [clns_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output clns_pkg::cfg_t                cfg
);

  logic [clns_pkg::WAIT_W-1:0] settle_r, settle_nxt;
  logic [clns_pkg::WAIT_W-1:0] clear_r, clear_nxt;
  logic                        wr_en;
  clns_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  // word address, byte offset bits ignored
  assign idx    = clns_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    settle_nxt = settle_r;
    clear_nxt  = clear_r;
    if (wr_en) begin
      case (idx)
        clns_pkg::REG_SETTLE: settle_nxt = pwdata[clns_pkg::WAIT_W-1:0];
        clns_pkg::REG_CLEAR:  clear_nxt  = pwdata[clns_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= clns_pkg::SETTLE_RESET;
      clear_r  <= clns_pkg::CLEAR_RESET;
    end else begin
      settle_r <= settle_nxt;
      clear_r  <= clear_nxt;
    end
  end

  always_comb begin
    case (idx)
      clns_pkg::REG_SETTLE:
        prdata = {{(clns_pkg::PDATA_W-clns_pkg::WAIT_W){1'b0}}, settle_r};
      clns_pkg::REG_CLEAR:
        prdata = {{(clns_pkg::PDATA_W-clns_pkg::WAIT_W){1'b0}}, clear_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.write_settle_us = settle_r;
  assign cfg.clear_wait_us   = clear_r;

endmodule

// ===== hdl/clns_step_unit.sv =====
// ----------------------------------------------------------------------------
// clns_step_unit
// shared step generator: maps request and step index to one lcd step
// ----------------------------------------------------------------------------
module clns_step_unit (
  input  clns_pkg::opcode_t              opcode,
  input  logic [7:0]                     byte_val,
  input  logic [clns_pkg::STEP_W-1:0]    step_idx,
  input  clns_pkg::cfg_t                 cfg,
  output clns_pkg::out_item_t            step
);

  clns_pkg::script_ent_t ent;
  clns_pkg::wait_sel_t   wsel;
  logic [clns_pkg::WAIT_W-1:0] wconst;

  always_comb begin
    ent             = clns_pkg::init_step(step_idx);
    step.reg_select = 1'b0;
    step.nibble     = 4'h0;
    step.strobe_res = 1'b0;
    step.last       = 1'b0;
    wsel            = clns_pkg::WAIT_CONST;
    wconst          = clns_pkg::WAIT_NONE;
    case (opcode)
      clns_pkg::OP_INIT: begin
        step.nibble     = ent.nibble;
        step.strobe_res = ent.strobe;
        wsel            = ent.wsel;
        wconst          = ent.wconst;
        step.last       = (step_idx == clns_pkg::STEP_W'(clns_pkg::INIT_STEPS - 1));
      end
      default: begin
        // byte: high nibble, low nibble, then the clear wait for a clear
        case (step_idx)
          5'd0: begin
            step.reg_select = (opcode == clns_pkg::OP_DATA);
            step.nibble     = byte_val[7:4];
            step.strobe_res = 1'b1;
          end
          5'd1: begin
            step.reg_select = (opcode == clns_pkg::OP_DATA);
            step.nibble     = byte_val[3:0];
            step.strobe_res = 1'b1;
            wsel            = clns_pkg::WAIT_SETTLE;
            step.last       = (opcode != clns_pkg::OP_CLEAR);
          end
          default: begin
            wsel      = clns_pkg::WAIT_CLEAR;
            step.last = 1'b1;
          end
        endcase
      end
    endcase
    case (wsel)
      clns_pkg::WAIT_SETTLE: step.wait_us = cfg.write_settle_us;
      clns_pkg::WAIT_CLEAR:  step.wait_us = cfg.clear_wait_us;
      default:               step.wait_us = wconst;
    endcase
  end

endmodule

// ===== tb/char_lcd_nibble_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_tb
// drives lcd requests through the valid/ready input, predicts every nibble
// step in the bench, and checks each step field by field as it leaves;
// settle and clear waits are rewritten over apb between phases
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb;
  import clns_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 54;
  localparam int DIR_ROWS    = 20;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // the bench's own view of the lcd power-up constants
  localparam logic [15:0] PWR_WAIT_LONG  = 16'd15000;
  localparam logic [15:0] PWR_WAIT_WAKE  = 16'd5000;
  localparam logic [15:0] PWR_WAIT_SHORT = 16'd1000;
  localparam logic [3:0]  PWR_NIB_WAKE   = 4'h3;
  localparam logic [3:0]  PWR_NIB_4BIT   = 4'h2;
  localparam logic [7:0]  LCD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0]  LCD_DISP_OFF   = 8'h08;
  localparam logic [7:0]  LCD_CLR_DISP   = 8'h01;
  localparam logic [7:0]  LCD_ENTRY_INC  = 8'h06;
  localparam logic [7:0]  LCD_DISP_CTRL  = 8'h0C;
  localparam logic [7:0]  LCD_GOTO       = 8'h80;
  localparam logic [7:0]  LCD_ROW_STRIDE = 8'h40;

  localparam out_item_t NO_STEP = '0;

  // settle / clear values written before phases 1.. (phase 3 is random)
  localparam logic [15:0] SETTLE_SET [PHASES-1] = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0};
  localparam logic [15:0] CLEAR_SET  [PHASES-1] = '{16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0};

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t hi;
    out_item_t lo;
  } dir_row_t;

  // directed requests; typed rows carry their two steps at reset settle 50
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{'{OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_DATA, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, 4'h0, 1'b1, 16'd0, 1'b0}, '{1'b1, 4'h0, 1'b1, 16'd50, 1'b1}},
    '{'{OP_DATA, 8'hFF, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, 4'hF, 1'b1, 16'd0, 1'b0}, '{1'b1, 4'hF, 1'b1, 16'd50, 1'b1}},
    '{'{OP_CMD, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 4'h0, 1'b1, 16'd0, 1'b0}, '{1'b0, 4'h0, 1'b1, 16'd50, 1'b1}},
    '{'{OP_CMD, 8'hFF, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 4'hF, 1'b1, 16'd0, 1'b0}, '{1'b0, 4'hF, 1'b1, 16'd50, 1'b1}},
    '{'{OP_DATA, 8'hA5, 6'd63, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CMD, 8'h5A, 6'd21, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_GOTO, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 4'h8, 1'b1, 16'd0, 1'b0}, '{1'b0, 4'h0, 1'b1, 16'd50, 1'b1}},
    '{'{OP_GOTO, 8'h00, 6'd63, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 4'hF, 1'b1, 16'd0, 1'b0}, '{1'b0, 4'hF, 1'b1, 16'd50, 1'b1}},
    '{'{OP_GOTO, 8'hFF, 6'd63, 1'b0, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_GOTO, 8'h00, 6'd0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CURSOR, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CURSOR, 8'hFF, 6'd63, 1'b1, 1'b0, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CURSOR, 8'h00, 6'd0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CURSOR, 8'h00, 6'd0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_SPARE_6, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_SPARE_7, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP, NO_STEP},
    '{'{OP_INIT, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP, NO_STEP}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [15:0] settle_us_sh = 16'd50;
  logic [15:0] clear_us_sh  = 16'd2000;
  out_item_t   lcd_steps_q [$];
  bit          idle_on      = 1'b1;
  int          err_cnt      = 0;
  int          cycle_cnt    = 0;

  char_lcd_nibble_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("char_lcd_nibble_sequencer_tb: errors");
      $finish;
    end
  end

  function automatic void push_step(input logic rs, input logic [3:0] nib,
                                    input logic strb, input logic [15:0] wait_us);
    lcd_steps_q.push_back('{reg_select: rs, nibble: nib, strobe_res: strb,
                            wait_us: wait_us, last: 1'b0});
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] value);
    push_step(rs, value[7:4], 1'b1, 16'd0);
    push_step(rs, value[3:0], 1'b1, settle_us_sh);
  endfunction

  // expected lcd steps of one request, appended to lcd_steps_q
  function automatic void predict_steps(input in_item_t it);
    int        n0;
    out_item_t tail;
    n0 = lcd_steps_q.size();
    case (it.opcode)
      OP_INIT: begin
        push_step(1'b0, 4'h0, 1'b0, PWR_WAIT_LONG);
        repeat (3) push_step(1'b0, PWR_NIB_WAKE, 1'b1, PWR_WAIT_WAKE);
        push_step(1'b0, PWR_NIB_4BIT, 1'b1, 16'd0);
        push_step(1'b0, 4'h0, 1'b0, PWR_WAIT_SHORT);
        push_byte(1'b0, LCD_FUNC_4BIT);
        push_byte(1'b0, LCD_DISP_OFF);
        push_byte(1'b0, LCD_CLR_DISP);
        push_step(1'b0, 4'h0, 1'b0, clear_us_sh);
        push_byte(1'b0, LCD_ENTRY_INC);
        push_byte(1'b0, LCD_DISP_CTRL);
      end
      OP_DATA:   push_byte(1'b1, it.byte_value);
      OP_CMD:    push_byte(1'b0, it.byte_value);
      OP_CLEAR: begin
        push_byte(1'b0, LCD_CLR_DISP);
        push_step(1'b0, 4'h0, 1'b0, clear_us_sh);
      end
      OP_GOTO:   push_byte(1'b0, LCD_GOTO | ({2'b00, it.column} +
                                             (it.row ? LCD_ROW_STRIDE : 8'h00)));
      OP_CURSOR: push_byte(1'b0, LCD_DISP_CTRL | {6'b0, it.cursor_on, it.cursor_blink});
      default: ;
    endcase
    if (lcd_steps_q.size() > n0) begin
      tail = lcd_steps_q.pop_back();
      tail.last = 1'b1;
      lcd_steps_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : step_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lcd_steps_q.size() == 0) begin
        $error("unexpected step: %p", out_data);
        err_cnt++;
      end else begin
        want = lcd_steps_q.pop_front();
        if (out_data.reg_select !== want.reg_select) begin
          $error("reg_select: exp %0h got %0h", want.reg_select, out_data.reg_select);
          err_cnt++;
        end
        if (out_data.nibble !== want.nibble) begin
          $error("nibble: exp %0h got %0h", want.nibble, out_data.nibble);
          err_cnt++;
        end
        if (out_data.strobe_res !== want.strobe_res) begin
          $error("strobe_res: exp %0h got %0h", want.strobe_res, out_data.strobe_res);
          err_cnt++;
        end
        if (out_data.wait_us !== want.wait_us) begin
          $error("wait_us: exp %0d got %0d", want.wait_us, out_data.wait_us);
          err_cnt++;
        end
        if (out_data.last !== want.last) begin
          $error("last: exp %0h got %0h", want.last, out_data.last);
          err_cnt++;
        end
      end
    end
  end

  // sink side: random stall bursts while idle_on
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_item(input in_item_t it, input logic typed,
                           input out_item_t hi, input out_item_t lo);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      lcd_steps_q.push_back(hi);
      lcd_steps_q.push_back(lo);
    end else begin
      predict_steps(it);
    end
  endtask

  // let every expected step out, then let any ignored requests settle
  task automatic drain_steps();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lcd_steps_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SETTLE) settle_us_sh = value;
    else clear_us_sh = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== value) begin
      $error("prdata: exp %0d got %0d", value, prdata[15:0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stim
    in_item_t    it;
    logic [31:0] raw;
    int          sent;
    int          pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIR_TBL[r].item, DIR_TBL[r].typed, DIR_TBL[r].hi, DIR_TBL[r].lo);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_steps();
        if (ph == 3) begin
          cfg_write(REG_SETTLE, 16'($urandom));
          cfg_write(REG_CLEAR, 16'($urandom));
        end else begin
          cfg_write(REG_SETTLE, SETTLE_SET[ph-1]);
          cfg_write(REG_CLEAR, CLEAR_SET[ph-1]);
        end
      end
      // closing phase runs at full rate on both sides
      idle_on = (ph != PHASES - 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        raw  = $urandom;
        it   = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) it.opcode = OP_INIT;
        else if (pick < 14) it.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        else it.opcode = 3'($urandom_range(1, 5));
        send_item(it, 1'b0, NO_STEP, NO_STEP);
        // spare opcodes are dropped by the block and do not count
        if (it.opcode <= OP_CURSOR) sent++;
      end
    end

    drain_steps();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("char_lcd_nibble_sequencer_tb: clean");
    end else begin
      $display("char_lcd_nibble_sequencer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/clns_pkg.sv
hdl/clns_cfg_regs.sv
hdl/clns_step_unit.sv
hdl/char_lcd_nibble_sequencer.sv
tb/char_lcd_nibble_sequencer_tb.sv
